// ===== rtl/wswd_pkg.sv =====
// shared widths, register indexes and reset values of the wake score window detector
package wswd_pkg;

    localparam int SCORE_W   = 8;
    localparam int THR_W     = 8;
    localparam int WLEN_W    = 5;
    localparam int COOL_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIN_LEN   = 2'd1,
        CFG_COOLOFF   = 2'd2
    } t_cfg_idx;

    localparam logic [THR_W-1:0]  THR_RST  = 8'd128;
    localparam logic [WLEN_W-1:0] WLEN_RST = 5'd5;
    localparam logic [COOL_W-1:0] COOL_RST = 10'd100;

endpackage

// ===== rtl/wake_score_window_detector.sv =====
// wake score window detector: running window sum, threshold test and cool-off counter
// an accepted score's result is registered in the output register in the next cycle
// throughput: one score per cycle while no sweep runs and the output is not stalled
// the window sum is kept as a running total; after reset and each window length write
//   it is rebuilt from the ring, one entry per cycle, and no score is taken meanwhile
// reset: synchronous active low; ring reads as zeros, cool-off loaded with 100
module wake_score_window_detector #(
    parameter int RING_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_score_valid,
    output logic                                o_score_ready,
    input  logic [wswd_pkg::SCORE_W-1:0]        i_score,
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic                                o_detected,
    output logic                                o_cooling_down,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wswd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wswd_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LEN_W  = $clog2(RING_DEPTH + 1);
    localparam int LW     = (LEN_W > wswd_pkg::WLEN_W) ? LEN_W : wswd_pkg::WLEN_W;
    localparam int CW     = LW + 1;
    localparam int SUM_W  = $clog2(RING_DEPTH * 255 + 1);
    localparam int PROD_W = wswd_pkg::THR_W + CW;
    localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

    logic [wswd_pkg::THR_W-1:0]   r_thr;
    logic [wswd_pkg::WLEN_W-1:0]  r_win_len;
    logic [wswd_pkg::COOL_W-1:0]  r_cool_cfg;

    logic [wswd_pkg::SCORE_W-1:0] r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0]        r_ring_vld;
    logic [wswd_pkg::SCORE_W-1:0] r_rd_data;
    logic [PTR_W-1:0]             r_rd_addr;

    logic [PTR_W-1:0]             r_ptr;
    logic [wswd_pkg::COOL_W-1:0]  r_cool;
    logic [SUM_W-1:0]             r_total;
    logic                         r_sweep;
    logic [CW-1:0]                r_cnt;

    logic                         r_res_valid;
    logic                         r_detected;
    logic                         r_cooling;

    logic [CW-1:0]                eff_len;
    logic [PTR_W-1:0]             p1;
    logic [PTR_W-1:0]             p2;
    logic [PTR_W-1:0]             rd_addr;
    logic [wswd_pkg::SCORE_W-1:0] rd_val;
    logic                         score_acc;
    logic                         cfg_acc;
    logic                         wlen_wr;
    logic                         sweep_rd;
    logic [SUM_W-1:0]             n_total;
    logic [PROD_W-1:0]            limit;
    logic                         eval;
    logic                         hit;
    logic [wswd_pkg::COOL_W-1:0]  n_cool;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [CW-1:0] len);
        logic [CW-1:0] nx;
        nx = CW'(p) + CW'(1);
        if (nx >= len) begin
            return '0;
        end
        return nx[PTR_W-1:0];
    endfunction

    always_comb begin
        if (r_win_len == '0) begin
            eff_len = CW'(1);
        end else if (CW'(r_win_len) > CW'(RING_DEPTH)) begin
            eff_len = CW'(RING_DEPTH);
        end else begin
            eff_len = CW'(r_win_len);
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign wlen_wr       = cfg_acc && (i_cfg_index == wswd_pkg::CFG_WIN_LEN);
    assign o_score_ready = !r_sweep && (!r_res_valid || i_result_ready);
    assign score_acc     = i_score_valid && o_score_ready;

    assign p1       = adv(r_ptr, eff_len);
    assign p2       = adv(p1, eff_len);
    assign sweep_rd = r_sweep && (r_cnt < eff_len);
    assign rd_addr  = sweep_rd ? r_cnt[PTR_W-1:0] : (score_acc ? p2 : p1);
    assign rd_val   = r_ring_vld[r_rd_addr] ? r_rd_data : '0;

    // running total with the old entry at the write slot swapped for the new score
    assign n_total = r_total - SUM_W'(rd_val) + SUM_W'(i_score);
    assign limit   = PROD_W'(r_thr) * PROD_W'(eff_len);
    assign eval    = (i_score >= r_thr) && (r_cool == '0);
    assign hit     = eval && (CMP_W'(n_total) > CMP_W'(limit));

    always_comb begin
        if (hit) begin
            n_cool = r_cool_cfg;
        end else if (r_cool != '0) begin
            n_cool = r_cool - 1'b1;
        end else begin
            n_cool = r_cool;
        end
    end

    // ring storage with a registered read port and write bypass
    always_ff @(posedge i_clk) begin
        if (score_acc) begin
            r_ring[p1] <= i_score;
        end
        if (score_acc && (p1 == rd_addr)) begin
            r_rd_data <= i_score;
        end else begin
            r_rd_data <= r_ring[rd_addr];
        end
        r_rd_addr <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= wswd_pkg::THR_RST;
            r_win_len   <= wswd_pkg::WLEN_RST;
            r_cool_cfg  <= wswd_pkg::COOL_RST;
            r_ring_vld  <= '0;
            r_ptr       <= '0;
            r_cool      <= wswd_pkg::COOL_RST;
            r_total     <= '0;
            r_sweep     <= 1'b1;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
            r_detected  <= 1'b0;
            r_cooling   <= 1'b0;
        end else begin
            if (score_acc) begin
                r_res_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_res_valid <= 1'b0;
            end

            // rebuild the window total one entry per cycle
            if (r_sweep && !wlen_wr) begin
                if (r_cnt == '0) begin
                    r_total <= '0;
                end else begin
                    r_total <= r_total + SUM_W'(rd_val);
                end
                if (r_cnt == eff_len) begin
                    r_sweep <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end

            if (score_acc) begin
                r_ptr       <= p1;
                r_cool      <= n_cool;
                r_detected  <= hit;
                r_cooling   <= (n_cool != '0);
                if (hit) begin
                    r_ring_vld <= '0;
                    r_total    <= '0;
                end else begin
                    r_ring_vld[p1] <= 1'b1;
                    r_total        <= n_total;
                end
            end

            if (cfg_acc) begin
                unique case (i_cfg_index)
                    wswd_pkg::CFG_THRESHOLD: begin
                        r_thr <= i_cfg_data[wswd_pkg::THR_W-1:0];
                    end
                    wswd_pkg::CFG_WIN_LEN: begin
                        r_win_len <= i_cfg_data[wswd_pkg::WLEN_W-1:0];
                        r_sweep   <= 1'b1;
                        r_cnt     <= '0;
                    end
                    wswd_pkg::CFG_COOLOFF: begin
                        r_cool_cfg <= i_cfg_data[wswd_pkg::COOL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_detected     = r_detected;
    assign o_cooling_down = r_cooling;

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the wake score window detector: random scores and settings
module tb_top;

    localparam int RING = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTINGS_PER_PHASE = 4;
    localparam int ITEMS_PER_SETTING = 117;
    localparam logic [wswd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef logic [wswd_pkg::THR_W-1:0]     t_thr;
    typedef logic [wswd_pkg::WLEN_W-1:0]    t_wlen;
    typedef logic [wswd_pkg::CFG_DAT_W-1:0] t_cfg_data;

    typedef struct packed {
        logic detected;
        logic cooling_down;
    } t_wake_flags;

    class wake_scoreboard;
        logic [wswd_pkg::THR_W-1:0]   threshold;
        logic [wswd_pkg::WLEN_W-1:0]  win_len;
        logic [wswd_pkg::COOL_W-1:0]  cooloff_load;
        logic [wswd_pkg::SCORE_W-1:0] recent[RING];
        int unsigned                  slot;
        logic [wswd_pkg::COOL_W-1:0]  cooloff_count;
        t_wake_flags                  expected_flags[$];
        int                           errors;

        function new();
            threshold     = wswd_pkg::THR_RST;
            win_len       = wswd_pkg::WLEN_RST;
            cooloff_load  = wswd_pkg::COOL_RST;
            cooloff_count = wswd_pkg::COOL_RST;
            slot          = 0;
            errors        = 0;
            foreach (recent[i]) recent[i] = '0;
        endfunction

        function void write_reg(logic [wswd_pkg::CFG_IDX_W-1:0] idx,
                                logic [wswd_pkg::CFG_DAT_W-1:0] data);
            case (idx)
                wswd_pkg::CFG_THRESHOLD: begin
                    threshold = data[wswd_pkg::THR_W-1:0];
                end
                wswd_pkg::CFG_WIN_LEN: begin
                    win_len = data[wswd_pkg::WLEN_W-1:0];
                end
                wswd_pkg::CFG_COOLOFF: begin
                    cooloff_load = data[wswd_pkg::COOL_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_score(logic [wswd_pkg::SCORE_W-1:0] score);
            int unsigned len;
            int unsigned total;
            t_wake_flags flags;
            len = (win_len == 0) ? 1 : (win_len > RING) ? RING : win_len;
            flags.detected = 1'b0;
            slot++;
            if (slot >= len) slot = 0;
            recent[slot % RING] = score;
            if (score < threshold || cooloff_count != 0) begin
                if (cooloff_count != 0) cooloff_count--;
            end else begin
                total = 0;
                for (int i = 0; i < len; i++) total += recent[i];
                if (total > threshold * len) begin
                    flags.detected = 1'b1;
                    foreach (recent[i]) recent[i] = '0;
                    cooloff_count = cooloff_load;
                end
            end
            flags.cooling_down = (cooloff_count != 0);
            expected_flags.push_back(flags);
        endfunction

        function void check_flags(logic detected, logic cooling_down);
            t_wake_flags want;
            if (expected_flags.size() == 0) begin
                $error("result item with no score pending");
                errors++;
                return;
            end
            want = expected_flags[0];
            expected_flags.delete(0);
            if (detected !== want.detected) begin
                $error("detected: expected %0b, got %0b", want.detected, detected);
                errors++;
            end
            if (cooling_down !== want.cooling_down) begin
                $error("cooling_down: expected %0b, got %0b", want.cooling_down, cooling_down);
                errors++;
            end
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_score_valid = 1'b0;
    logic                                o_score_ready;
    logic [wswd_pkg::SCORE_W-1:0]        i_score = '0;
    logic                                o_result_valid;
    logic                                i_result_ready = 1'b0;
    logic                                o_detected;
    logic                                o_cooling_down;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [wswd_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [wswd_pkg::CFG_DAT_W-1:0]      i_cfg_data = '0;

    wake_scoreboard sb = new();
    int send_idle = 0;
    int recv_stall = 0;
    int quiet_cycles = 0;

    wake_score_window_detector #(.RING_DEPTH(RING)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_score_valid  (i_score_valid),
        .o_score_ready  (o_score_ready),
        .i_score        (i_score),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_detected     (o_detected),
        .o_cooling_down (o_cooling_down),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_result_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_score_valid && o_score_ready) sb.note_score(i_score);
            if (o_result_valid && i_result_ready) sb.check_flags(o_detected, o_cooling_down);
            if ((i_cfg_valid && o_cfg_ready) || (i_score_valid && o_score_ready)
                    || (o_result_valid && i_result_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $error("no handshake for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_score(input logic [wswd_pkg::SCORE_W-1:0] value);
        while ($urandom_range(99) < send_idle) begin
            i_score_valid = 1'b0;
            @(negedge i_clk);
        end
        i_score_valid = 1'b1;
        i_score = value;
        @(posedge i_clk);
        while (!o_score_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [wswd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wswd_pkg::CFG_DAT_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        i_score_valid = 1'b0;
        while (sb.expected_flags.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // upper data bits are random so the register width masking is exercised
    task automatic apply_setting(input int thr, input int wlen, input int cool);
        t_cfg_data data;
        wait_drained();
        data = t_cfg_data'($urandom);
        write_reg(CFG_UNUSED_IDX, data);
        data = t_cfg_data'($urandom);
        data[wswd_pkg::THR_W-1:0] = t_thr'(thr);
        write_reg(wswd_pkg::CFG_THRESHOLD, data);
        data = t_cfg_data'($urandom);
        data[wswd_pkg::WLEN_W-1:0] = t_wlen'(wlen);
        write_reg(wswd_pkg::CFG_WIN_LEN, data);
        data = t_cfg_data'(cool);
        write_reg(wswd_pkg::CFG_COOLOFF, data);
    endtask

    // mostly scores near or above the cutoff so windows fill and fire
    function automatic logic [wswd_pkg::SCORE_W-1:0] pick_score(int thr);
        int roll;
        int value;
        roll = $urandom_range(99);
        if (roll < 30) value = $urandom_range(255);
        else if (roll < 75) value = thr + int'($urandom_range(24)) - 8;
        else value = $urandom_range(255, thr);
        if (value < 0) value = 0;
        if (value > 255) value = 255;
        return value[wswd_pkg::SCORE_W-1:0];
    endfunction

    int extreme_thr[8]  = '{0, 255, 200, 100, 60, 150, 128, 90};
    int extreme_wlen[8] = '{0, 31, 16, 17, 1, 8, 3, 12};
    int extreme_cool[8] = '{0, 1023, 3, 0, 2, 0, 5, 1};
    int idle_tab[4]  = '{0, 53, 0, 23};
    int stall_tab[4] = '{0, 0, 53, 23};
    logic [wswd_pkg::SCORE_W-1:0] edge_scores[10] = '{8'd0, 8'd255, 8'd128, 8'd127, 8'h55,
                                                      8'hAA, 8'd1, 8'd254, 8'h0F, 8'hF0};

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // edge scores while the reset cool-off is still running
        foreach (edge_scores[i]) send_score(edge_scores[i]);
        apply_setting(wswd_pkg::THR_RST, wswd_pkg::WLEN_RST, wswd_pkg::COOL_RST);
        send_score(8'd255);
        send_score(8'd0);

        for (int p = 0; p < 4; p++) begin
            send_idle = idle_tab[p];
            recv_stall = stall_tab[p];
            for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
                if (s < 2) begin
                    apply_setting(extreme_thr[p*2+s], extreme_wlen[p*2+s],
                                  extreme_cool[p*2+s]);
                end else if ($urandom_range(3) == 0) begin
                    apply_setting($urandom_range(230, 40), $urandom_range(31),
                                  $urandom_range(20));
                end else begin
                    apply_setting($urandom_range(230, 40), $urandom_range(16, 1),
                                  $urandom_range(12));
                end
                repeat (ITEMS_PER_SETTING) send_score(pick_score(sb.threshold));
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_flags.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== wake_score_window_detector.f =====
rtl/wswd_pkg.sv
rtl/wake_score_window_detector.sv
sim/tb_top.sv
